FILE: hw/rtl/sorted_unique_insert_table_defines.svh
// ----------------------------------------------------------------------------
// Sorted unique insert table: assertion macros
// Shared property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_UNIQUE_INSERT_TABLE_DEFINES_SVH
`define SORTED_UNIQUE_INSERT_TABLE_DEFINES_SVH

// Same-cycle implication, off during reset.
`define SUIT_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define SUIT_ASSERT_NEXT(lbl, clk, ante, cons, msg, rstn) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define SUIT_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/suit_pkg.sv
// ----------------------------------------------------------------------------
// Sorted unique insert table: package
// Field widths, result status codes and the per-cell flag bundle.
// ----------------------------------------------------------------------------
package suit_pkg;

    localparam int VALUE_W = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W = 3;
    localparam int COUNT_W = 4;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_INSERTED = 2'd0;
    localparam t_status ST_DUPLICATE = 2'd1;
    localparam t_status ST_FULL = 2'd2;

    typedef logic signed [VALUE_W-1:0] t_value;

    // ins: the new value belongs at or before this cell; eq: cell holds it
    typedef struct packed {
        logic ins;
        logic eq;
    } t_cell_flags;

endpackage

FILE: hw/rtl/suit_if.sv
// ----------------------------------------------------------------------------
// Sorted unique insert table: channel interfaces
// Valid/ready channels for the value input and the result output.
// ----------------------------------------------------------------------------
interface suit_in_if import suit_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value new_value;

    modport source (output valid, output new_value, input ready);
    modport sink (input valid, input new_value, output ready);
endinterface

interface suit_out_if import suit_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output status, output position, output count,
                    input ready);
    modport sink (input valid, input status, input position, input count,
                  output ready);
endinterface

FILE: hw/rtl/suit_cell.sv
// ----------------------------------------------------------------------------
// Sorted unique insert table: storage cell
// Holds one table entry, compares it with the offered value and takes either
// its left neighbor's entry or the new value when an insert shifts the row.
// ----------------------------------------------------------------------------
module suit_cell import suit_pkg::*; (
    input  logic        i_clk,
    input  logic        i_occupied,
    input  t_value      i_value,
    input  t_value      i_left_entry,
    input  logic        i_left_ins,
    input  logic        i_shift,
    output t_value      o_entry,
    output t_cell_flags o_flags
);

    t_value r_entry;

    always_comb begin
        o_flags.eq  = i_occupied && (r_entry == i_value);
        o_flags.ins = !i_occupied || (r_entry > i_value);
    end

    // Left neighbor also past the slot: move up; first slot: take the value
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            if (i_left_ins) begin
                r_entry <= i_left_entry;
            end else if (o_flags.ins) begin
                r_entry <= i_value;
            end
        end
    end

    assign o_entry = r_entry;

endmodule

FILE: hw/rtl/sorted_unique_insert_table.sv
// Path: the accepted value is registered, then the result is registered on commit.
// Throughput: one value per cycle unless the result stalls; all cells compare
// and shift in the commit cycle, so a new value enters as the last result drains.
// Reset: synchronous, active low; clears the entry count and the pipeline
// valid flags. Entries hold garbage until written and are never read unused.
// ----------------------------------------------------------------------------
// Sorted unique insert table: top level
// Row of cells keeping an ascending, duplicate-free table of signed values.
// ----------------------------------------------------------------------------
module sorted_unique_insert_table import suit_pkg::*; #(
    parameter int CAPACITY = 8
) (
    input logic        i_clk,
    input logic        i_rst_n,
    suit_in_if.sink    i_in,
    suit_out_if.source o_out
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]    r_count;
    logic                r_busy;
    t_value              r_value;
    logic                r_out_valid;
    t_status             r_status;
    logic [POS_W-1:0]    r_pos;
    logic [COUNT_W-1:0]  r_cnt;

    logic [CNT_W-1:0]    n_count;
    t_status             n_status;
    logic [POS_W-1:0]    n_pos;
    logic [COUNT_W-1:0]  n_cnt;

    t_value              w_entry [CAPACITY];
    t_cell_flags         w_flags [CAPACITY];
    logic [CAPACITY-1:0] w_occ;
    logic [CAPACITY-1:0] w_eq;
    logic [CAPACITY-1:0] w_slot;
    logic [IDX_W-1:0]    w_slot_idx;
    logic                w_dup;
    logic                w_full;
    logic                w_out_free;
    logic                w_commit;
    logic                w_insert;
    logic                w_accept;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_commit   = r_busy && w_out_free;
    assign i_in.ready = !r_busy || w_out_free;
    assign w_accept   = i_in.valid && i_in.ready;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_head
                suit_cell u_cell (
                    .i_clk        (i_clk),
                    .i_occupied   (w_occ[g]),
                    .i_value      (r_value),
                    .i_left_entry (r_value),
                    .i_left_ins   (1'b0),
                    .i_shift      (w_insert),
                    .o_entry      (w_entry[g]),
                    .o_flags      (w_flags[g])
                );
                assign w_slot[g] = w_flags[g].ins;
            end else begin : g_body
                suit_cell u_cell (
                    .i_clk        (i_clk),
                    .i_occupied   (w_occ[g]),
                    .i_value      (r_value),
                    .i_left_entry (w_entry[g-1]),
                    .i_left_ins   (w_flags[g-1].ins),
                    .i_shift      (w_insert),
                    .o_entry      (w_entry[g]),
                    .o_flags      (w_flags[g])
                );
                assign w_slot[g] = w_flags[g].ins && !w_flags[g-1].ins;
            end
            assign w_occ[g] = CNT_W'(g) < r_count;
            assign w_eq[g]  = w_flags[g].eq;
        end
    endgenerate

    // One-hot slot to index: OR together the indexes of the marked cell
    always_comb begin
        w_slot_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_slot[i]) begin
                w_slot_idx = w_slot_idx | IDX_W'(i);
            end
        end
    end

    assign w_dup    = |w_eq;
    assign w_full   = r_count == CNT_W'(CAPACITY);
    assign w_insert = w_commit && !w_dup && !w_full;

    always_comb begin
        n_count = w_insert ? r_count + CNT_W'(1) : r_count;
        if (w_dup) begin
            n_status = ST_DUPLICATE;
            n_pos    = '0;
        end else if (w_full) begin
            n_status = ST_FULL;
            n_pos    = '0;
        end else begin
            n_status = ST_INSERTED;
            n_pos    = POS_W'({{POS_W{1'b0}}, w_slot_idx});
        end
        n_cnt = COUNT_W'({{COUNT_W{1'b0}}, n_count});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_commit) begin
                r_busy <= 1'b0;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value <= i_in.new_value;
        end
        if (w_commit) begin
            r_status <= n_status;
            r_pos    <= n_pos;
            r_cnt    <= n_cnt;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.status   = r_status;
    assign o_out.position = r_pos;
    assign o_out.count    = r_cnt;

endmodule

FILE: hw/rtl/suit_chk.sv
// ----------------------------------------------------------------------------
// Sorted unique insert table: port checker
// Watches the result channel for legal codes, reject positions, stall behavior and reset.
// ----------------------------------------------------------------------------
`include "sorted_unique_insert_table_defines.svh"

module suit_chk import suit_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic [POS_W-1:0]    i_position,
    input logic [COUNT_W-1:0]  i_count
);

    `SUIT_ASSERT_IMPLY(a_status_legal, i_clk, i_rst_n, i_out_valid, (i_status == ST_INSERTED || i_status == ST_DUPLICATE || i_status == ST_FULL), "illegal status code")
    `SUIT_ASSERT_IMPLY(a_reject_pos_zero, i_clk, i_rst_n, i_out_valid && i_status != ST_INSERTED, i_position == '0, "rejected transaction with nonzero position")
    `SUIT_ASSERT_NEXT(a_stall_hold, i_clk, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_position) && $stable(i_count), "stalled result changed", i_rst_n)
    `SUIT_ASSERT_ALWAYS_NEXT(a_reset_idle, i_clk, !i_rst_n, !i_out_valid, "result valid after reset")

endmodule

bind sorted_unique_insert_table suit_chk u_suit_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_position  (o_out.position),
    .i_count     (o_out.count)
);

FILE: verif/sorted_unique_insert_table_test.sv
// ----------------------------------------------------------------------------
// Sorted unique insert table: testbench
// Fills the table through a short list of hand-picked values (extremes,
// duplicates, the full table), then offers random values that are mostly
// stored ones, near misses of stored ones, or noise. Every result is checked
// against an in-bench model of the table or a typed-in result, under four
// patterns of idling on the input and output channels.
// ----------------------------------------------------------------------------
module sorted_unique_insert_table_test;
    import suit_pkg::*;

    localparam int TABLE_DEPTH = 8;
    localparam int PHASE_ITEMS = 375;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int LONG_HOLD_AFTER = 150;

    typedef struct packed {
        t_status            status;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
    } insert_result;

    // pinned: the result is typed in here instead of taken from the model
    typedef struct packed {
        t_value       value;
        logic         pinned;
        insert_result result;
    } staged_value;

    localparam int DIRECTED_ROWS = 18;

    staged_value directed_rows [DIRECTED_ROWS] = '{
        '{32'sh0000_0000, 1'b1, '{ST_INSERTED,  3'd0, 4'd1}},
        '{32'sh0000_0000, 1'b1, '{ST_DUPLICATE, 3'd0, 4'd1}},
        '{32'sh7FFF_FFFF, 1'b1, '{ST_INSERTED,  3'd1, 4'd2}},
        '{32'sh8000_0000, 1'b1, '{ST_INSERTED,  3'd0, 4'd3}},
        '{32'sh7FFF_FFFF, 1'b1, '{ST_DUPLICATE, 3'd0, 4'd3}},
        '{32'sh8000_0000, 1'b1, '{ST_DUPLICATE, 3'd0, 4'd3}},
        '{32'shFFFF_FFFF, 1'b1, '{ST_INSERTED,  3'd1, 4'd4}},
        '{32'sh0000_0001, 1'b0, '0},
        '{32'sh7FFF_FFFE, 1'b0, '0},
        '{32'sh8000_0001, 1'b0, '0},
        '{32'sh5555_5555, 1'b0, '0},
        '{32'sh0000_0002, 1'b1, '{ST_FULL,      3'd0, 4'd8}},
        // duplicate in a full table reports duplicate, not full
        '{32'shFFFF_FFFF, 1'b1, '{ST_DUPLICATE, 3'd0, 4'd8}},
        '{32'shAAAA_AAAA, 1'b1, '{ST_FULL,      3'd0, 4'd8}},
        '{32'sh7FFF_FFFF, 1'b1, '{ST_DUPLICATE, 3'd0, 4'd8}},
        '{32'sh8000_0000, 1'b1, '{ST_DUPLICATE, 3'd0, 4'd8}},
        '{32'sh7FFF_FFFD, 1'b1, '{ST_FULL,      3'd0, 4'd8}},
        '{32'sh5555_5555, 1'b1, '{ST_DUPLICATE, 3'd0, 4'd8}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    suit_in_if  in_ch ();
    suit_out_if out_ch ();

    sorted_unique_insert_table #(
        .CAPACITY (TABLE_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model of the table
    t_value held_values [TABLE_DEPTH];
    int     held_count = 0;

    staged_value  staged_values [$];
    insert_result pending_results [$];

    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          failures = 0;
    int          inserted_total = 0;
    int          duplicate_total = 0;
    int          full_total = 0;
    int          idle_cycles = 0;
    int          hold_left = 0;
    bit          long_hold_done = 1'b0;

    function automatic insert_result apply_insert(t_value v);
        insert_result r;
        int           gap;
        bit           hit;
        hit = 1'b0;
        for (int i = 0; i < held_count; i++) begin
            if (held_values[i] == v) hit = 1'b1;
        end
        r.position = '0;
        if (hit) begin
            r.status = ST_DUPLICATE;
        end else if (held_count >= TABLE_DEPTH) begin
            r.status = ST_FULL;
        end else begin
            // shift larger entries up and drop the value into the gap
            gap = held_count;
            while (gap > 0 && held_values[gap-1] > v) begin
                held_values[gap] = held_values[gap-1];
                gap--;
            end
            held_values[gap] = v;
            held_count++;
            r.position = POS_W'(gap);
            r.status = ST_INSERTED;
        end
        r.count = COUNT_W'(held_count);
        return r;
    endfunction

    // mostly stored values and single-bit near misses, some plain noise
    function automatic t_value pick_value();
        t_value stored;
        stored = (held_count > 0) ? held_values[$urandom_range(held_count - 1)]
                                  : t_value'($urandom);
        case ($urandom_range(3))
            0, 1:    return stored;
            2:       return stored ^ (t_value'(1) << $urandom_range(VALUE_W - 1));
            default: return t_value'($urandom);
        endcase
    endfunction

    task automatic offer(input staged_value item);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        staged_values.push_back(item);
        in_ch.valid <= 1'b1;
        in_ch.new_value <= item.value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // hold the input until every result has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (results_seen != items_sent) @(posedge i_clk);
    endtask

    task automatic check_field(string field, int expected, int actual);
        if (expected != actual) begin
            $error("%s mismatch: expected %0d, actual %0d", field, expected, actual);
            failures++;
        end
    endtask

    // result side: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
            out_ch.ready <= 1'b0;
            hold_left <= LONG_HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        insert_result got;
        insert_result want;
        insert_result predicted;
        staged_value  item;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.status, out_ch.position, out_ch.count};
                if (pending_results.size() == 0) begin
                    $error("result transaction with nothing pending: status %0d",
                           got.status);
                    failures++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", int'(want.status), int'(got.status));
                    check_field("position", int'(want.position), int'(got.position));
                    check_field("count", int'(want.count), int'(got.count));
                end
                results_seen++;
            end
            if (in_ch.valid && in_ch.ready) begin
                item = staged_values.pop_front();
                predicted = apply_insert(in_ch.new_value);
                want = item.pinned ? item.result : predicted;
                case (want.status)
                    ST_INSERTED:  inserted_total++;
                    ST_DUPLICATE: duplicate_total++;
                    default:      full_total++;
                endcase
                pending_results.push_back(want);
            end
        end
    end

    // count cycles in which neither channel moves a transaction
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        staged_value item;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.new_value = '0;
        out_ch.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) offer(directed_rows[r]);

        for (int phase = 0; phase < 4; phase++) begin
            drain();
            case (phase)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin sender_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                item = '{pick_value(), 1'b0, '0};
                offer(item);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            failures++;
        end

        $display("Sent %0d values: %0d inserted, %0d duplicates, %0d rejected as full,",
                 items_sent, inserted_total, duplicate_total, full_total);
        $display("across no idling, sender gaps, result stalls and both together.");
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
